### rtl/apsp_pkg.sv
// Shared constants and types for the all-pairs shortest path block.
`timescale 1ns / 1ps
package apsp_pkg;
  localparam int NODES_DEF     = 8;
  localparam int DIST_BITS_DEF = 16;
  localparam int NODE_W        = 3;
  localparam int WEIGHT_W      = 16;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 24;

  // operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RELAX,
    ST_EMIT
  } state_t;

  // per-cycle control handed to every cell
  typedef struct packed {
    logic shift;  // take the neighbor's handed row
    logic relax;  // hand the relaxed row instead of the stored one
  } cell_ctrl_t;
endpackage

### rtl/apsp_cell.sv
// One cell of the ring: holds one matrix row and relaxes it against the pivot row.
`timescale 1ns / 1ps
module apsp_cell #(
  parameter int NODES     = apsp_pkg::NODES_DEF,
  parameter int DIST_BITS = apsp_pkg::DIST_BITS_DEF,
  parameter int IDX_BITS  = (NODES > 1) ? $clog2(NODES) : 1
) (
  input  logic                             clk,
  input  apsp_pkg::cell_ctrl_t             ctrl,
  input  logic                             wr_en,
  input  logic [IDX_BITS-1:0]              wr_col,
  input  logic [DIST_BITS-1:0]             wr_data,
  input  logic [IDX_BITS-1:0]              pivot_idx,
  input  logic [NODES-1:0][DIST_BITS-1:0]  pivot_row,
  input  logic [NODES-1:0][DIST_BITS-1:0]  row_in,
  output logic [NODES-1:0][DIST_BITS-1:0]  row_out,
  output logic [NODES-1:0][DIST_BITS-1:0]  hand_out
);
  import apsp_pkg::*;

  localparam logic [DIST_BITS-1:0] INF = {DIST_BITS{1'b1}};

  logic [NODES-1:0][DIST_BITS-1:0] row_r;
  logic [NODES-1:0][DIST_BITS-1:0] row_nxt;
  logic [NODES-1:0][DIST_BITS-1:0] relaxed;
  logic [DIST_BITS-1:0]            d_ik;

  assign d_ik = row_r[pivot_idx];

  // saturating relaxation of each entry through the pivot node
  always_comb begin
    for (int j = 0; j < NODES; j++) begin
      logic [DIST_BITS:0] s;
      logic [DIST_BITS-1:0] sat;
      s = {1'b0, d_ik} + {1'b0, pivot_row[j]};
      if (d_ik == INF || pivot_row[j] == INF || s >= {1'b0, INF}) begin
        sat = INF;
      end else begin
        sat = s[DIST_BITS-1:0];
      end
      relaxed[j] = (sat < row_r[j]) ? sat : row_r[j];
    end
  end

  assign hand_out = ctrl.relax ? relaxed : row_r;
  assign row_out  = row_r;

  // row register: shift from neighbor or single-entry write
  always_comb begin
    row_nxt = row_r;
    if (ctrl.shift) begin
      row_nxt = row_in;
    end else if (wr_en) begin
      row_nxt[wr_col] = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end
endmodule

### rtl/all_pairs_shortest_path.sv
// Top level: ring of row cells, run sequencer and result register.
//
// Channel | Dir | tdata (low bit up)                     | tuser / tlast
// in_     | in  | row[2:0] col[5:3] weight[21:6]         | tuser = operation
// out_    | out | src_node[2:0] dst_node[5:3] dist[21:6] | tlast = last
//
// A write request updates one matrix entry. A run request relaxes every row
// through each node in turn as pivot (one pivot row per cycle, rotating through
// the cell ring), then emits NODES*NODES results; output stalls hold the emit
// sequencer. Reset clears only control; the matrix is undefined until written.
`timescale 1ns / 1ps
module all_pairs_shortest_path #(
  parameter int NODES     = apsp_pkg::NODES_DEF,
  parameter int DIST_BITS = apsp_pkg::DIST_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [apsp_pkg::IN_DATA_W-1:0]  in_tdata,  // row, col, weight
  input  logic                            in_tuser,  // operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [apsp_pkg::OUT_DATA_W-1:0] out_tdata, // src_node, dst_node, distance
  output logic                            out_tlast  // last
);
  import apsp_pkg::*;

  localparam int IDX_BITS = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int WB       = (DIST_BITS > WEIGHT_W) ? DIST_BITS : WEIGHT_W;
  localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(NODES - 1);
  localparam logic [WB-1:0]       INF_EXT  = WB'({DIST_BITS{1'b1}});

  state_t state_r, state_nxt;
  logic [IDX_BITS-1:0] k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0]   out_src_r, out_src_nxt, out_dst_r, out_dst_nxt;
  logic [WEIGHT_W-1:0] out_dist_r, out_dist_nxt;
  logic                out_last_r, out_last_nxt;

  cell_ctrl_t ctrl;
  logic       in_acc, wr_ok;
  logic [NODE_W-1:0]    f_row, f_col;
  logic [WEIGHT_W-1:0]  f_weight;
  logic [WB-1:0]        w_ext, w_clamp;
  logic [DIST_BITS-1:0] wr_data;

  logic [NODES-1:0][NODES-1:0][DIST_BITS-1:0] rows, hands;

  assign f_row    = in_tdata[2:0];
  assign f_col    = in_tdata[5:3];
  assign f_weight = in_tdata[21:6];
  assign in_acc   = in_tvalid && in_tready;
  assign wr_ok    = in_acc && (in_tuser == OP_WRITE) &&
                    ({1'b0, f_row} < (NODE_W + 1)'(NODES)) &&
                    ({1'b0, f_col} < (NODE_W + 1)'(NODES));
  assign w_ext    = WB'(f_weight);
  assign w_clamp  = (w_ext > INF_EXT) ? INF_EXT : w_ext;
  assign wr_data  = w_clamp[DIST_BITS-1:0];

  // ring of cells: cell c takes the row handed by cell c+1
  for (genvar c = 0; c < NODES; c++) begin : g_cell
    apsp_cell #(.NODES(NODES), .DIST_BITS(DIST_BITS), .IDX_BITS(IDX_BITS)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .wr_en     (wr_ok && (f_row[IDX_BITS-1:0] == IDX_BITS'(c))),
      .wr_col    (f_col[IDX_BITS-1:0]),
      .wr_data   (wr_data),
      .pivot_idx (k_r),
      .pivot_row (rows[0]),
      .row_in    (hands[(c + 1) % NODES]),
      .row_out   (rows[c]),
      .hand_out  (hands[c])
    );
  end

  // sequencer: next state, counters, result register
  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    out_valid_nxt = out_valid_r;
    out_src_nxt   = out_src_r;
    out_dst_nxt   = out_dst_r;
    out_dist_nxt  = out_dist_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    in_tready     = 1'b0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && in_tuser == OP_RUN) begin
          state_nxt = ST_RELAX;
          k_nxt     = '0;
        end
      end
      ST_RELAX: begin
        ctrl.shift = 1'b1;
        ctrl.relax = 1'b1;
        k_nxt      = k_r + 1'b1;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_EMIT;
          i_nxt     = '0;
          j_nxt     = '0;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = NODE_W'(i_r);
          out_dst_nxt   = NODE_W'(j_r);
          out_dist_nxt  = WEIGHT_W'(WB'(rows[0][j_r]));
          out_last_nxt  = (i_r == LAST_IDX) && (j_r == LAST_IDX);
          j_nxt         = j_r + 1'b1;
          if (j_r == LAST_IDX) begin
            j_nxt      = '0;
            i_nxt      = i_r + 1'b1;
            ctrl.shift = 1'b1;
            if (i_r == LAST_IDX) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_src_r  <= out_src_nxt;
    out_dst_r  <= out_dst_nxt;
    out_dist_r <= out_dist_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_dist_r, out_dst_r, out_src_r};

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE)
    else $error("input ready outside idle");
  a_relax_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RELAX && k_r != LAST_IDX) |=> state_r == ST_RELAX)
    else $error("relaxation cut short");
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      (out_src_r == NODE_W'(LAST_IDX) && out_dst_r == NODE_W'(LAST_IDX)))
    else $error("last flag on wrong entry");
`endif
endmodule

### verif/tb_all_pairs_shortest_path.sv
// Self-checking testbench for the all-pairs shortest path block.
`timescale 1ns / 1ps
module tb_all_pairs_shortest_path;
  import apsp_pkg::*;

  localparam int N = NODES_DEF;
  localparam logic [WEIGHT_W-1:0] INF = '1;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic                op;
    logic [NODE_W-1:0]   row;
    logic [NODE_W-1:0]   col;
    logic [WEIGHT_W-1:0] weight;
  } apsp_req_t;

  typedef struct packed {
    logic [NODE_W-1:0]   src;
    logic [NODE_W-1:0]   dst;
    logic [WEIGHT_W-1:0] distance;
    logic                last;
  } dist_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;

  all_pairs_shortest_path dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the distance matrix
  logic [WEIGHT_W-1:0] shadow_dist [N][N];
  apsp_req_t pending_reqs[$];
  dist_res_t expected_dists[$];
  int errors = 0;
  int runs_done = 0;
  int results_seen = 0;
  int idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  bit hold_send = 1'b0;

  function automatic logic [WEIGHT_W-1:0] sum_sat(logic [WEIGHT_W-1:0] a,
                                                  logic [WEIGHT_W-1:0] b);
    logic [WEIGHT_W:0] s;
    if (a == INF || b == INF) return INF;
    s = {1'b0, a} + {1'b0, b};
    return (s >= {1'b0, INF}) ? INF : s[WEIGHT_W-1:0];
  endfunction

  // apply one accepted request to the shadow matrix and queue its results
  task automatic predict_request(apsp_req_t r);
    logic [WEIGHT_W-1:0] s;
    dist_res_t e;
    if (r.op == OP_WRITE) begin
      shadow_dist[r.row][r.col] = r.weight;
      return;
    end
    for (int k = 0; k < N; k++)
      for (int i = 0; i < N; i++)
        for (int j = 0; j < N; j++) begin
          s = sum_sat(shadow_dist[i][k], shadow_dist[k][j]);
          if (shadow_dist[i][j] > s) shadow_dist[i][j] = s;
        end
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++) begin
        e.src = NODE_W'(i); e.dst = NODE_W'(j); e.distance = shadow_dist[i][j];
        e.last = (i == N - 1 && j == N - 1);
        expected_dists.push_back(e);
      end
  endtask

  function automatic apsp_req_t mk_req(logic op, int r, int c, int w);
    apsp_req_t q;
    q.op = op; q.row = NODE_W'(r); q.col = NODE_W'(c); q.weight = WEIGHT_W'(w);
    return q;
  endfunction

  function automatic int rand_weight();
    case ($urandom_range(0, 5))
      0: return INF;
      1: return $urandom_range(0, 15);
      2: return $urandom_range(16'hFF00, 16'hFFFE);
      3: return $urandom_range(16'h7F00, 16'h8100);
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // random edits to the already loaded matrix followed by a run
  task automatic queue_graph(int density);
    int i, j;
    for (int n = 0; n < 25; n++) begin
      i = $urandom_range(0, N - 1);
      j = $urandom_range(0, N - 1);
      pending_reqs.push_back(mk_req(OP_WRITE, i, j,
        (i == j && $urandom_range(0, 3) != 0) ? 0 :
        ($urandom_range(0, 99) < density) ? rand_weight() : INF));
    end
    pending_reqs.push_back(mk_req(OP_RUN, $urandom_range(0, 7), $urandom_range(0, 7),
                                  $urandom_range(0, 16'hFFFF)));
  endtask

  // driver: one request per handshake from the pending queue
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_request(pending_reqs.pop_front());
      if ((!in_tvalid || in_tready) || !rst_n) begin
        if (pending_reqs.size() > (in_tvalid && in_tready ? 0 : 0) && !hold_send &&
            !((idle_mode == 1 && $urandom_range(0, 99) < 88) ||
              (idle_mode == 3 && $urandom_range(0, 99) < 31))) begin
          in_tvalid <= 1'b1;
          in_tuser  <= pending_reqs[0].op;
          in_tdata  <= {2'b00, pending_reqs[0].weight, pending_reqs[0].col,
                        pending_reqs[0].row};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_tready <= !((idle_mode == 2 && $urandom_range(0, 99) < 88) ||
                    (idle_mode == 3 && $urandom_range(0, 99) < 31));
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    dist_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[2:0], out_tdata[5:3], out_tdata[21:6], out_tlast};
      results_seen++;
      if (expected_dists.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = expected_dists.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected src=%0d dst=%0d dist=%0d last=%0d",
                   $time, want.src, want.dst, want.distance, want.last);
          $display("%0t:          actual   src=%0d dst=%0d dist=%0d last=%0d",
                   $time, got.src, got.dst, got.distance, got.last);
        end
        if (want.last) runs_done++;
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** all_pairs_shortest_path: FAILED **");
      $finish;
    end
  end

  initial begin
    // directed: extremes and special cases
    for (int i = 0; i < N; i++)
      for (int j = 0; j < N; j++)
        pending_reqs.push_back(mk_req(OP_WRITE, i, j, (i == j) ? 0 : INF));
    pending_reqs.push_back(mk_req(OP_WRITE, 0, 7, 16'hFFFE));
    pending_reqs.push_back(mk_req(OP_WRITE, 7, 0, 16'h0001));
    pending_reqs.push_back(mk_req(OP_WRITE, 7, 3, 16'h8000));
    pending_reqs.push_back(mk_req(OP_WRITE, 3, 5, 16'h7FFF));
    pending_reqs.push_back(mk_req(OP_WRITE, 5, 2, 16'h0000));
    pending_reqs.push_back(mk_req(OP_WRITE, 2, 6, 16'h5555));
    pending_reqs.push_back(mk_req(OP_WRITE, 6, 4, 16'hAAAA));
    pending_reqs.push_back(mk_req(OP_RUN, 7, 7, 16'hFFFF));
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase;
      if (phase > 0) queue_graph($urandom_range(20, 95));
      if (phase == 1) queue_graph(100);
      wait (pending_reqs.size() == 0);
      // hold off until every distance of the phase has come back
      hold_send = 1'b1;
      wait (expected_dists.size() == 0);
      repeat (4) @(posedge clk);
      hold_send = 1'b0;
    end
    idle_mode = 0;
    repeat (50) @(posedge clk);

    $display("Ran %0d relaxation runs, %0d distances checked, across four idling phases.",
             runs_done, results_seen);
    if (errors == 0 && expected_dists.size() == 0) begin
      $display("** all_pairs_shortest_path: PASSED **");
    end else begin
      $display("** all_pairs_shortest_path: FAILED **");
    end
    $finish;
  end
endmodule

### all_pairs_shortest_path.f
rtl/apsp_pkg.sv
rtl/apsp_cell.sv
rtl/all_pairs_shortest_path.sv
verif/tb_all_pairs_shortest_path.sv
